// File: rtl/lcg_pkg.sv
// Shared constants, types and the sine table builder for the lidar corridor guard.
`timescale 1ns / 1ps
`default_nettype none

package lcg_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_PINGS_DEF = 4096;
   localparam int TRIG_BITS_DEF = 10;

   // Field widths
   localparam int ANGLE_W    = 16;
   localparam int RANGE_W    = 16;
   localparam int SPEED_W    = 16;
   localparam int INDEX_W    = 12;
   localparam int RADIUS_W   = 12;
   localparam int CORNER_W   = 15;
   localparam int STEP_W     = 12;
   localparam int TRIG_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = 33;
   localparam int QUARTER_FRAC_W = ANGLE_W - 2;

   // Binary angles, 65536 per turn
   localparam logic [ANGLE_W-1:0] QUARTER_TURN   = 16'h4000;
   localparam logic [14:0]        QUARTER_TURN_F = 15'h4000;
   localparam logic signed [16:0] QUARTER_S      = 17'sd16384;
   localparam logic signed [16:0] HALF_TURN_S    = 17'sd32768;

   // Command adjustment on alarm
   localparam logic signed [16:0] STEER_BIAS  = 17'sd10;
   localparam logic [16:0]        DIV10_MUL   = 17'd52429;
   localparam int                 DIV10_SHIFT = 19;
   localparam int                 QUOT_W      = 13;

   // Register reset values
   localparam logic [15:0]         SAFE_DISTANCE_RST = 16'd500;
   localparam logic [RADIUS_W-1:0] ROBOT_RADIUS_RST  = 12'd150;
   localparam logic [CORNER_W-1:0] CORNER_ANGLE_RST  = 15'd13428;
   localparam logic signed [15:0]  FIRST_ANGLE_RST   = 16'sd0;
   localparam logic [STEP_W-1:0]   ANGLE_STEP_RST    = 12'd64;
   localparam logic [INDEX_W-1:0]  RIGHT_INDEX_RST   = 12'd0;
   localparam logic [INDEX_W-1:0]  LEFT_INDEX_RST    = 12'd4095;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAFE_DISTANCE = 3'd0,
      CSR_ROBOT_RADIUS  = 3'd1,
      CSR_CORNER_ANGLE  = 3'd2,
      CSR_FIRST_ANGLE   = 3'd3,
      CSR_ANGLE_STEP    = 3'd4,
      CSR_RIGHT_INDEX   = 3'd5,
      CSR_LEFT_INDEX    = 3'd6
   } csr_index_type;

   // Transaction state after the sector decision, handed to the check stage
   typedef struct packed {
      logic                      kind;
      logic                      last;
      logic [RANGE_W-1:0]        range_mm;
      logic signed [SPEED_W-1:0] linear_cmd;
      logic signed [SPEED_W-1:0] angular_cmd;
      logic                      in_window;
      logic                      side_right;
      logic                      mid;
      logic                      side_left;
      logic                      on_right;
      logic                      trig_neg;
   } ping_stage_type;

   // One Q15 quarter-wave sine sample, Q30 Taylor series to x^13.
   // Only evaluated with constant arguments while the table is elaborated.
   function automatic logic [TRIG_W-1:0] sin_sample(input int unsigned k,
                                                    input int unsigned bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x    = (64'(k) * 64'd1686629713) >> bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      v = (sum + 64'd16384) >> 15;
      if (v > 64'd32768) begin
         v = 64'd32768;
      end
      return v[TRIG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/lcg_sin_rom.sv
// Quarter-wave sine ROM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lcg_sin_rom
   import lcg_pkg::*;
#(
   parameter int TRIG_BITS = TRIG_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [TRIG_BITS:0]   rd_addr,
   output logic      [TRIG_W-1:0]    rd_data
);

   localparam int ROM_DEPTH = (1 << TRIG_BITS) + 1;

   logic [TRIG_W-1:0] rom_tbl [ROM_DEPTH];
   logic [TRIG_W-1:0] rd_data_ff;

   // Constant contents, built at elaboration
   for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_tbl
      assign rom_tbl[k] = sin_sample(k, TRIG_BITS);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_tbl[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lcg_front.sv
// Input register, ping counter, sector decision and sine lookup.
`timescale 1ns / 1ps
`default_nettype none

module lcg_front
   import lcg_pkg::*;
#(
   parameter int MAX_PINGS = MAX_PINGS_DEF,
   parameter int TRIG_BITS = TRIG_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire logic                       req_valid,
   input  wire logic                       req_kind,
   input  wire logic [RANGE_W-1:0]         req_range_mm,
   input  wire logic                       req_last,
   input  wire logic signed [SPEED_W-1:0]  req_linear_cmd,
   input  wire logic signed [SPEED_W-1:0]  req_angular_cmd,
   input  wire logic [CORNER_W-1:0]        corner_angle,
   input  wire logic signed [ANGLE_W-1:0]  first_angle,
   input  wire logic [STEP_W-1:0]          angle_step,
   input  wire logic [INDEX_W-1:0]         right_index,
   input  wire logic [INDEX_W-1:0]         left_index,
   output logic                            s2_valid,
   output ping_stage_type                  s2_ping,
   output logic [TRIG_W-1:0]               rom_data
);

   localparam int CNT_W  = $clog2(MAX_PINGS);
   localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int ADDR_W = TRIG_BITS + 1;

   logic                      accept;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ANGLE_W-1:0]        angle_ff, angle_in;
   logic                      in_window;
   logic [ANGLE_W-1:0]        u_in;

   logic                      s1_valid_ff;
   logic                      s1_kind_ff;
   logic                      s1_last_ff;
   logic [RANGE_W-1:0]        s1_range_ff;
   logic signed [SPEED_W-1:0] s1_lin_ff;
   logic signed [SPEED_W-1:0] s1_ang_ff;
   logic [ANGLE_W-1:0]        s1_u_ff;
   logic                      s1_win_ff;

   logic signed [16:0]        a_ext, c_ext, c_far;
   logic                      side_right, mid, side_left, on_right;
   logic [ANGLE_W-1:0]        look;
   logic [14:0]               folded, folded_sh;
   logic [ADDR_W-1:0]         rom_addr;

   logic                      s2_valid_ff;
   ping_stage_type            s2_ping_ff, s2_ping_in;

   assign accept = req_valid & adv;

   // Ping index and angle of the next ping; a last ping or ping MAX_PINGS - 1 restarts the scan
   always_comb begin
      count_in = count_ff;
      angle_in = angle_ff;
      if (accept && req_kind) begin
         if (req_last || count_ff == CNT_W'(MAX_PINGS - 1)) begin
            count_in = '0;
            angle_in = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
            angle_in = angle_ff + ANGLE_W'(angle_step);
         end
      end
   end

   assign in_window = (CMP_W'(count_ff) >= CMP_W'(right_index)) &&
                      (CMP_W'(count_ff) <= CMP_W'(left_index));
   assign u_in = $unsigned(first_angle) + angle_ff;

   // Sector decision on the signed ping angle
   assign a_ext      = {s1_u_ff[ANGLE_W-1], s1_u_ff};
   assign c_ext      = {2'b00, corner_angle};
   assign c_far      = HALF_TURN_S - c_ext;
   assign side_right = a_ext < c_ext;
   assign mid        = (a_ext > c_ext) && (a_ext < c_far);
   assign side_left  = a_ext > c_far;
   assign on_right   = a_ext < QUARTER_S;

   // Middle sector needs sine, the sides need cosine; fold into the quarter wave
   assign look      = mid ? s1_u_ff : (s1_u_ff + QUARTER_TURN);
   assign folded    = look[ANGLE_W-2] ? (QUARTER_TURN_F - {1'b0, look[QUARTER_FRAC_W-1:0]})
                                      : {1'b0, look[QUARTER_FRAC_W-1:0]};
   assign folded_sh = folded >> (QUARTER_FRAC_W - TRIG_BITS);
   assign rom_addr  = folded_sh[ADDR_W-1:0];

   always_comb begin
      s2_ping_in.kind        = s1_kind_ff;
      s2_ping_in.last        = s1_last_ff;
      s2_ping_in.range_mm    = s1_range_ff;
      s2_ping_in.linear_cmd  = s1_lin_ff;
      s2_ping_in.angular_cmd = s1_ang_ff;
      s2_ping_in.in_window   = s1_win_ff;
      s2_ping_in.side_right  = side_right;
      s2_ping_in.mid         = mid;
      s2_ping_in.side_left   = side_left;
      s2_ping_in.on_right    = on_right;
      s2_ping_in.trig_neg    = look[ANGLE_W-1];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         angle_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         angle_ff <= angle_in;
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff  <= req_kind;
         s1_last_ff  <= req_last;
         s1_range_ff <= req_range_mm;
         s1_lin_ff   <= req_linear_cmd;
         s1_ang_ff   <= req_angular_cmd;
         s1_u_ff     <= u_in;
         s1_win_ff   <= in_window;
         s2_ping_ff  <= s2_ping_in;
      end
   end

   lcg_sin_rom #(
      .TRIG_BITS (TRIG_BITS)
   ) u_sin_rom (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   assign s2_valid = s2_valid_ff;
   assign s2_ping  = s2_ping_ff;

endmodule

`default_nettype wire

// File: rtl/lcg_check.sv
// Clearance multiply, hit latch, held command and result register.
`timescale 1ns / 1ps
`default_nettype none

module lcg_check
   import lcg_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       s2_valid,
   input  wire ping_stage_type             s2_ping,
   input  wire logic [TRIG_W-1:0]          rom_data,
   input  wire logic [15:0]                safe_distance,
   input  wire logic [RADIUS_W-1:0]        robot_radius,
   input  wire logic                       rsp_ready,
   output logic                            adv,
   output logic                            rsp_valid,
   output logic signed [SPEED_W-1:0]       rsp_linear_out,
   output logic signed [SPEED_W-1:0]       rsp_angular_out,
   output logic                            rsp_alarm
);

   logic [RANGE_W-1:0]        lin_mag;
   logic [RANGE_W-1:0]        mul_a;
   logic [16:0]               mul_b;
   logic [PROD_W-1:0]         prod_in;
   logic                      trig_zero, eligible;

   logic                      s3_valid_ff;
   logic                      s3_kind_ff, s3_last_ff;
   logic [PROD_W-1:0]         s3_prod_ff;
   logic                      s3_elig_ff, s3_mid_ff, s3_win_ff, s3_right_ff;
   logic                      s3_lin_neg_ff;
   logic signed [SPEED_W-1:0] s3_lin_ff, s3_ang_ff;

   logic                      hit_flag_ff, hit_right_ff;
   logic signed [SPEED_W-1:0] held_lin_ff, held_ang_ff, held_slow_ff;

   logic [15:0]               lim;
   logic [PROD_W-1:0]         lim_sh;
   logic                      ping_hit, emit, hit_now, right_now;
   logic [QUOT_W-1:0]         quot;
   logic signed [SPEED_W-1:0] slow_in;
   logic signed [16:0]        bias_sum;
   logic signed [SPEED_W-1:0] ang_sat, out_lin, out_ang;

   logic                      rsp_valid_ff, rsp_alarm_ff;
   logic signed [SPEED_W-1:0] rsp_lin_ff, rsp_ang_ff;

   // Shared multiplier: range times trig on pings, reciprocal of ten on commands
   assign lin_mag   = s2_ping.linear_cmd[SPEED_W-1] ? $unsigned(-s2_ping.linear_cmd)
                                                    : $unsigned(s2_ping.linear_cmd);
   assign mul_a     = s2_ping.kind ? s2_ping.range_mm : lin_mag;
   assign mul_b     = s2_ping.kind ? {1'b0, rom_data} : DIV10_MUL;
   assign prod_in   = {17'b0, mul_a} * {16'b0, mul_b};

   // Right and middle sectors need a non-negative trig value, the left sector a negative one; zero counts for either
   assign trig_zero = rom_data == '0;
   assign eligible  = ((s2_ping.side_right || s2_ping.mid) && (!s2_ping.trig_neg || trig_zero)) ||
                      (s2_ping.side_left && (s2_ping.trig_neg || trig_zero));

   // Clearance compare against the limit scaled to Q15
   assign lim      = s3_mid_ff ? safe_distance : {4'b0, robot_radius};
   assign lim_sh   = {2'b00, lim, 15'b0};
   assign ping_hit = s3_win_ff && s3_elig_ff && !hit_flag_ff && (s3_prod_ff < lim_sh);

   // Slowed linear speed, divided toward zero
   assign quot    = s3_prod_ff[DIV10_SHIFT +: QUOT_W];
   assign slow_in = s3_lin_neg_ff ? -$signed({3'b000, quot}) : $signed({3'b000, quot});

   // Result of a last ping, including its own check
   assign emit      = s3_valid_ff && s3_kind_ff && s3_last_ff;
   assign hit_now   = hit_flag_ff || ping_hit;
   assign right_now = hit_flag_ff ? hit_right_ff : s3_right_ff;
   assign bias_sum  = {held_ang_ff[SPEED_W-1], held_ang_ff} + (right_now ? STEER_BIAS : -STEER_BIAS);

   always_comb begin
      if (bias_sum > 17'sd32767) begin
         ang_sat = 16'sh7fff;
      end else if (bias_sum < -17'sd32768) begin
         ang_sat = -16'sh8000;
      end else begin
         ang_sat = bias_sum[SPEED_W-1:0];
      end
   end

   assign out_lin = hit_now ? held_slow_ff : held_lin_ff;
   assign out_ang = hit_now ? ang_sat : held_ang_ff;

   // Hold the pipeline only when a result meets a full output register
   assign adv = !(emit && rsp_valid_ff && !rsp_ready);

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         hit_flag_ff  <= 1'b0;
         hit_right_ff <= 1'b0;
         held_lin_ff  <= '0;
         held_ang_ff  <= '0;
         held_slow_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s3_valid_ff <= s2_valid;
         end
         if (adv && s3_valid_ff) begin
            if (!s3_kind_ff) begin
               held_lin_ff  <= s3_lin_ff;
               held_ang_ff  <= s3_ang_ff;
               held_slow_ff <= slow_in;
            end else if (s3_last_ff) begin
               hit_flag_ff  <= 1'b0;
               hit_right_ff <= 1'b0;
            end else if (ping_hit) begin
               hit_flag_ff  <= 1'b1;
               hit_right_ff <= s3_right_ff;
            end
         end
         if (emit && adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_kind_ff    <= s2_ping.kind;
         s3_last_ff    <= s2_ping.last;
         s3_prod_ff    <= prod_in;
         s3_elig_ff    <= eligible;
         s3_mid_ff     <= s2_ping.mid;
         s3_win_ff     <= s2_ping.in_window;
         s3_right_ff   <= s2_ping.on_right;
         s3_lin_neg_ff <= s2_ping.linear_cmd[SPEED_W-1];
         s3_lin_ff     <= s2_ping.linear_cmd;
         s3_ang_ff     <= s2_ping.angular_cmd;
      end
      if (emit && adv) begin
         rsp_lin_ff   <= out_lin;
         rsp_ang_ff   <= out_ang;
         rsp_alarm_ff <= hit_now;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_linear_out  = rsp_lin_ff;
   assign rsp_angular_out = rsp_ang_ff;
   assign rsp_alarm       = rsp_alarm_ff;

endmodule

`default_nettype wire

// File: rtl/lidar_corridor_guard.sv
// Top level of the lidar corridor guard: registers, front end and check stage.
//
//   Channel  Ports   Direction  Moves
//   req      req_*   in         velocity command or lidar ping
//   rsp      rsp_*   out        guarded command at the end of a scan
//   csr      csr_*   in         register write (index, data), always ready
//
// One transaction is taken per cycle while the input is not stalled. A result
// passes the input register, sine ROM read, multiply and result register.
// The ROM's registered read and the single shared multiplier set the depth.
// Reset is synchronous; it restores register defaults and clears the scan.
// While a result waits unaccepted, other transactions keep flowing; the input
// stalls only when a second result reaches the full result register.
`timescale 1ns / 1ps
`default_nettype none

module lidar_corridor_guard
   import lcg_pkg::*;
#(
   parameter int MAX_PINGS = MAX_PINGS_DEF,
   parameter int TRIG_BITS = TRIG_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_kind,
   input  wire logic [RANGE_W-1:0]           req_range_mm,
   input  wire logic                         req_last,
   input  wire logic signed [SPEED_W-1:0]    req_linear_cmd,
   input  wire logic signed [SPEED_W-1:0]    req_angular_cmd,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [SPEED_W-1:0]         rsp_linear_out,
   output logic signed [SPEED_W-1:0]         rsp_angular_out,
   output logic                              rsp_alarm,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data
);

   logic [15:0]               safe_distance_ff;
   logic [RADIUS_W-1:0]       robot_radius_ff;
   logic [CORNER_W-1:0]       corner_angle_ff;
   logic signed [ANGLE_W-1:0] first_angle_ff;
   logic [STEP_W-1:0]         angle_step_ff;
   logic [INDEX_W-1:0]        right_index_ff;
   logic [INDEX_W-1:0]        left_index_ff;

   logic                      adv;
   logic                      s2_valid;
   ping_stage_type            s2_ping;
   logic [TRIG_W-1:0]         rom_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         safe_distance_ff <= SAFE_DISTANCE_RST;
         robot_radius_ff  <= ROBOT_RADIUS_RST;
         corner_angle_ff  <= CORNER_ANGLE_RST;
         first_angle_ff   <= FIRST_ANGLE_RST;
         angle_step_ff    <= ANGLE_STEP_RST;
         right_index_ff   <= RIGHT_INDEX_RST;
         left_index_ff    <= LEFT_INDEX_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SAFE_DISTANCE: safe_distance_ff <= csr_data;
            CSR_ROBOT_RADIUS:  robot_radius_ff  <= csr_data[RADIUS_W-1:0];
            CSR_CORNER_ANGLE:  corner_angle_ff  <= csr_data[CORNER_W-1:0];
            CSR_FIRST_ANGLE:   first_angle_ff   <= $signed(csr_data);
            CSR_ANGLE_STEP:    angle_step_ff    <= csr_data[STEP_W-1:0];
            CSR_RIGHT_INDEX:   right_index_ff   <= csr_data[INDEX_W-1:0];
            CSR_LEFT_INDEX:    left_index_ff    <= csr_data[INDEX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = adv;

   lcg_front #(
      .MAX_PINGS (MAX_PINGS),
      .TRIG_BITS (TRIG_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .req_valid       (req_valid),
      .req_kind        (req_kind),
      .req_range_mm    (req_range_mm),
      .req_last        (req_last),
      .req_linear_cmd  (req_linear_cmd),
      .req_angular_cmd (req_angular_cmd),
      .corner_angle    (corner_angle_ff),
      .first_angle     (first_angle_ff),
      .angle_step      (angle_step_ff),
      .right_index     (right_index_ff),
      .left_index      (left_index_ff),
      .s2_valid        (s2_valid),
      .s2_ping         (s2_ping),
      .rom_data        (rom_data)
   );

   lcg_check u_check (
      .clock           (clock),
      .reset           (reset),
      .s2_valid        (s2_valid),
      .s2_ping         (s2_ping),
      .rom_data        (rom_data),
      .safe_distance   (safe_distance_ff),
      .robot_radius    (robot_radius_ff),
      .rsp_ready       (rsp_ready),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_linear_out  (rsp_linear_out),
      .rsp_angular_out (rsp_angular_out),
      .rsp_alarm       (rsp_alarm)
   );

endmodule

`default_nettype wire

// File: rtl/lcg_checker.sv
// Port-level assertions for the lidar corridor guard, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lcg_checker
   import lcg_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_ready,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic signed [SPEED_W-1:0]    rsp_linear_out,
   input  wire logic signed [SPEED_W-1:0]    rsp_angular_out,
   input  wire logic                         rsp_alarm
);

   // No result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A waiting result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_linear_out) &&
                                  $stable(rsp_angular_out) && $stable(rsp_alarm))
      else $error("result changed while stalled");

   // Input backpressure only comes from a blocked result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");

   // On alarm the linear speed lies within the range left by division by ten
   a_alarm_slow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alarm |-> (rsp_linear_out <= 16'sd3276) &&
                                 (rsp_linear_out >= -16'sd3276))
      else $error("alarm result with unreduced linear speed");

endmodule

bind lidar_corridor_guard lcg_checker u_lcg_checker (.*);

`default_nettype wire
